[hw/rtl/akd_pkg.sv]
// ----------------------------------------------------------------------------
// Keypad decoder package
// Shared types, button codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package akd_pkg;

   typedef logic [2:0] button_type;

   localparam button_type BTN_RIGHT  = 3'd0;
   localparam button_type BTN_UP     = 3'd1;
   localparam button_type BTN_DOWN   = 3'd2;
   localparam button_type BTN_LEFT   = 3'd3;
   localparam button_type BTN_SELECT = 3'd4;
   localparam button_type BTN_NONE   = 3'd5;

   localparam int SCALED_BITS = 10;
   localparam logic [SCALED_BITS-1:0] TEN_BIT_MAX = 10'd1023;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 16;

   localparam logic [CSR_INDEX_BITS-1:0] REG_FULL_SCALE = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_STABLE     = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_RIGHT      = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_UP         = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_DOWN       = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] REG_LEFT       = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SELECT     = 3'd6;

   localparam logic [15:0] RST_FULL_SCALE = 16'd4095;
   localparam logic [7:0]  RST_STABLE     = 8'd3;
   localparam logic [9:0]  RST_RIGHT      = 10'd80;
   localparam logic [9:0]  RST_UP         = 10'd200;
   localparam logic [9:0]  RST_DOWN       = 10'd400;
   localparam logic [9:0]  RST_LEFT       = 10'd600;
   localparam logic [9:0]  RST_SELECT     = 10'd800;

endpackage

[hw/rtl/akd_div.sv]
// ----------------------------------------------------------------------------
// Keypad decoder rescale divider
// Restoring divider, one quotient bit per cycle, eleven steps; a quotient
// above the ten-bit range saturates.
// ----------------------------------------------------------------------------
module akd_div #(
   parameter int NUM_BITS = 27
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [NUM_BITS-1:0]                dividend,
   input  logic [15:0]                        divisor,
   output logic                               done,
   output logic [akd_pkg::SCALED_BITS-1:0]    quotient
);

   localparam int QUO_BITS = akd_pkg::SCALED_BITS + 1;
   localparam int DSR_BITS = 16 + akd_pkg::SCALED_BITS;
   localparam int WIDE     = (NUM_BITS > DSR_BITS) ? NUM_BITS : DSR_BITS + 1;

   logic [WIDE-1:0]     rem_ff, rem_in;
   logic [WIDE-1:0]     dsr_ff, dsr_in;
   logic [QUO_BITS-1:0] quo_ff, quo_in;
   logic [3:0]          step_ff, step_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [15:0]         div_safe;

   assign div_safe = (divisor == 16'd0) ? 16'd1 : divisor;

   always_comb begin
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      quo_in  = quo_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = WIDE'(dividend);
         dsr_in  = WIDE'({div_safe, {akd_pkg::SCALED_BITS{1'b0}}});
         quo_in  = '0;
         step_in = 4'(QUO_BITS - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (rem_ff >= dsr_ff) begin
            rem_in = rem_ff - dsr_ff;
            quo_in = {quo_ff[QUO_BITS-2:0], 1'b1};
         end else begin
            quo_in = {quo_ff[QUO_BITS-2:0], 1'b0};
         end
         dsr_in  = dsr_ff >> 1;
         step_in = step_ff - 4'd1;
         if (step_ff == 4'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      dsr_ff  <= dsr_in;
      quo_ff  <= quo_in;
      step_ff <= step_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff[QUO_BITS-1] ? akd_pkg::TEN_BIT_MAX
                                         : quo_ff[QUO_BITS-2:0];

endmodule

[hw/rtl/analog_ladder_keypad_decoder.sv]
// ----------------------------------------------------------------------------
// Analog ladder keypad decoder
// Rescales raw ladder samples to ten bits, decodes the button and debounces.
// ----------------------------------------------------------------------------
// Each accepted sample beat yields one result beat once the result side is
// ready. The scale state forms the rounded numerator and starts the
// restoring divider, which loads and then produces the eleven quotient bits
// one at a time; the saturated quotient is captured when the divider reports
// done. The decode state then decodes the button, updates the debouncer and
// loads the output register. One sample is in flight at a time.
// The next sample beat can be taken in the cycle after the result is
// registered. A stalled result holds the decode step and with it the
// input.
module analog_ladder_keypad_decoder #(
   parameter int SAMPLE_BITS = 16,
   parameter int COUNT_BITS  = 8
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // [15:0] raw_sample
   input  logic [15:0]                           req_tdata,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // [2:0] stable_button, [12:3] scaled_value, [15:13] zero
   output logic [15:0]                           rsp_tdata,
   input  logic                                  csr_wen,
   input  logic [akd_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [akd_pkg::CSR_DATA_BITS-1:0]     csr_wdata
);

   localparam int NUM_BITS = SAMPLE_BITS + 11;
   localparam int CMP_BITS = (COUNT_BITS > 8) ? COUNT_BITS : 8;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCALE  = 2'd1;
   localparam logic [1:0] ST_DIVIDE = 2'd2;
   localparam logic [1:0] ST_DECODE = 2'd3;

   logic [15:0] full_scale_ff;
   logic [7:0]  stable_ff;
   logic [9:0]  right_ff, up_ff, down_ff, left_ff, select_ff;

   logic [1:0]             state_ff;
   logic [SAMPLE_BITS-1:0] raw_ff;
   logic [NUM_BITS-1:0]    num_ff;
   logic                   start_ff;
   logic [9:0]             scaled_ff;
   logic                   div_done;
   logic [9:0]             div_quo;

   akd_pkg::button_type cand_ff, cand_in;
   akd_pkg::button_type stable_btn_ff, stable_btn_in;
   logic [COUNT_BITS-1:0] agree_ff, agree_in;
   akd_pkg::button_type cls;

   logic                  rsp_valid_ff;
   logic [15:0]           rsp_data_ff;
   logic                  out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         full_scale_ff <= akd_pkg::RST_FULL_SCALE;
         stable_ff     <= akd_pkg::RST_STABLE;
         right_ff      <= akd_pkg::RST_RIGHT;
         up_ff         <= akd_pkg::RST_UP;
         down_ff       <= akd_pkg::RST_DOWN;
         left_ff       <= akd_pkg::RST_LEFT;
         select_ff     <= akd_pkg::RST_SELECT;
      end else if (csr_wen) begin
         case (csr_index)
            akd_pkg::REG_FULL_SCALE: full_scale_ff <= csr_wdata;
            akd_pkg::REG_STABLE:     stable_ff     <= csr_wdata[7:0];
            akd_pkg::REG_RIGHT:      right_ff      <= csr_wdata[9:0];
            akd_pkg::REG_UP:         up_ff         <= csr_wdata[9:0];
            akd_pkg::REG_DOWN:       down_ff       <= csr_wdata[9:0];
            akd_pkg::REG_LEFT:       left_ff       <= csr_wdata[9:0];
            akd_pkg::REG_SELECT:     select_ff     <= csr_wdata[9:0];
            default: begin
            end
         endcase
      end
   end

   akd_div #(
      .NUM_BITS (NUM_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (start_ff),
      .dividend (num_ff),
      .divisor  (full_scale_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   always_comb begin
      if (scaled_ff <= right_ff) begin
         cls = akd_pkg::BTN_RIGHT;
      end else if (scaled_ff <= up_ff) begin
         cls = akd_pkg::BTN_UP;
      end else if (scaled_ff <= down_ff) begin
         cls = akd_pkg::BTN_DOWN;
      end else if (scaled_ff <= left_ff) begin
         cls = akd_pkg::BTN_LEFT;
      end else if (scaled_ff <= select_ff) begin
         cls = akd_pkg::BTN_SELECT;
      end else begin
         cls = akd_pkg::BTN_NONE;
      end
   end

   always_comb begin
      cand_in       = cand_ff;
      agree_in      = agree_ff;
      stable_btn_in = stable_btn_ff;
      if (cls != cand_ff) begin
         cand_in  = cls;
         agree_in = COUNT_BITS'(1);
      end else if ((CMP_BITS'(agree_ff) < CMP_BITS'(stable_ff)) && (agree_ff != '1)) begin
         agree_in = agree_ff + COUNT_BITS'(1);
      end
      if (CMP_BITS'(agree_in) >= CMP_BITS'(stable_ff)) begin
         stable_btn_in = cand_in;
      end
   end

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         start_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         cand_ff       <= akd_pkg::BTN_NONE;
         stable_btn_ff <= akd_pkg::BTN_NONE;
         agree_ff      <= '0;
      end else begin
         start_ff <= (state_ff == ST_SCALE);
         if ((state_ff == ST_DECODE) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  state_ff <= ST_SCALE;
               end
            end
            ST_SCALE: begin
               state_ff <= ST_DIVIDE;
            end
            ST_DIVIDE: begin
               if (div_done) begin
                  state_ff <= ST_DECODE;
               end
            end
            ST_DECODE: begin
               if (out_free) begin
                  cand_ff       <= cand_in;
                  agree_ff      <= agree_in;
                  stable_btn_ff <= stable_btn_in;
                  state_ff      <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         raw_ff <= req_tdata[SAMPLE_BITS-1:0];
      end
      if (state_ff == ST_SCALE) begin
         num_ff <= NUM_BITS'({raw_ff, 10'd0}) - NUM_BITS'(raw_ff)
                   + NUM_BITS'(full_scale_ff[15:1]);
      end
      if (div_done) begin
         scaled_ff <= div_quo;
      end
      if (state_ff == ST_DECODE && out_free) begin
         rsp_data_ff <= {3'd0, scaled_ff, stable_btn_in};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

[hw/rtl/akd_checker.sv]
// ----------------------------------------------------------------------------
// Keypad decoder port checker
// Watches the top-level ports for handshake and result sanity.
// ----------------------------------------------------------------------------
module akd_checker (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   input  logic                                  req_tready,
   input  logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   input  logic [15:0]                           rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("Result beat changed while stalled.");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready ##1 !req_tready)
      else $error("Sample beat accepted while a sample was in flight.");

   a_button_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[2:0] <= akd_pkg::BTN_NONE)
                     && (rsp_tdata[15:13] == 3'd0))
      else $error("Result beat carries an invalid button code or padding.");

   a_no_early_result: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !rsp_tvalid |=> !rsp_tvalid ##1 !rsp_tvalid)
      else $error("Result beat appeared too soon after a sample beat.");

endmodule

bind analog_ladder_keypad_decoder akd_checker u_akd_checker (.*);
